>>> design/rmst_pkg.sv
package rmst_pkg;

   localparam int WORD_W = 32;
   localparam int IDX_W  = 10;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]         idx_type;

   // mode field codes
   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // fold starting point, also the answer for a bad range
   localparam word_type FLOOR_VALUE = -32'sd99999999;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY,
      ST_DRAIN
   } state_type;

   function automatic word_type max_word(input word_type a, input word_type b);
      max_word = (a > b) ? a : b;
   endfunction

endpackage

>>> design/rmst_mem.sv
module rmst_mem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  rmst_pkg::word_type wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output rmst_pkg::word_type rd_data_a,
   output rmst_pkg::word_type rd_data_b
);
   import rmst_pkg::*;

   word_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> design/range_max_segment_tree_core.sv
// Bottom-up segment tree of signed 32-bit maxima over LEAVES positions, held in one
// memory of 2*LEAVES words with one write port and two registered read ports. After
// reset the block clears the memory one word per cycle and takes no word on req_ until
// that pass is done. One word is in work at a time. An update walks from the leaf to
// the root writing one node per cycle, holding the block until the root is written;
// the write of each node and the sibling read for its parent fall in the same cycle, the
// running value being kept in a register rather than read back. A query climbs one
// tree level per cycle with both read ports, then folds the pairs read into a running
// maximum and presents the result from the drain state; a range outside
// 1 <= left <= right <= LEAVES-2 goes straight to the drain state and answers with the
// floor value and the error bit. Updates give no rsp_ word. The rsp_ word sits in an
// output register until taken; a query that finishes while that register is still
// full waits for it.
module range_max_segment_tree_core #(
   parameter int unsigned LEAVES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  rmst_pkg::idx_type    req_first_index,
   input  rmst_pkg::idx_type    req_last_index,
   input  rmst_pkg::word_type   req_new_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rmst_pkg::word_type   rsp_range_max,
   output logic                 rsp_range_error
);
   import rmst_pkg::*;

   localparam int NODE_W = $clog2(2 * LEAVES);
   localparam int DEPTH  = 2 * LEAVES;
   localparam int CMP_W  = ((NODE_W > IDX_W) ? NODE_W : IDX_W) + 1;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(DEPTH - 1);
   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
   localparam logic [CMP_W-1:0]  LEAVES_C  = CMP_W'(LEAVES);
   localparam logic [CMP_W-1:0]  LAST_OK   = CMP_W'(LEAVES - 2);
   localparam logic [CMP_W-1:0]  ONE_C     = CMP_W'(1);

   state_type state_ff, state_in;

   logic [NODE_W-1:0] node_ff, node_in;     // clear address, or node being written
   word_type          val_ff, val_in;       // value of the child just written
   logic              upd_first_ff, upd_first_in;
   logic [NODE_W-1:0] lo_ff, lo_in;
   logic [NODE_W-1:0] hi_ff, hi_in;
   logic              sel_a_ff, sel_a_in;
   logic              sel_b_ff, sel_b_in;
   word_type          pair_ff, pair_in;
   word_type          best_ff, best_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   word_type          rsp_max_ff, rsp_max_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              mem_we;
   logic [NODE_W-1:0] mem_waddr;
   word_type          mem_wdata;
   logic [NODE_W-1:0] mem_raddr_a;
   logic [NODE_W-1:0] mem_raddr_b;
   word_type          rd_a;
   word_type          rd_b;

   logic [CMP_W-1:0]  first_w;
   logic [CMP_W-1:0]  last_w;
   logic              range_ok;
   logic              upd_ok;
   logic              climb;
   word_type          upd_wdata;

   rmst_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (NODE_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign first_w  = CMP_W'(req_first_index);
   assign last_w   = CMP_W'(req_last_index);
   assign range_ok = (first_w >= ONE_C) && (first_w <= last_w) && (last_w <= LAST_OK);
   assign upd_ok   = first_w < LEAVES_C;

   // bounds still apart: neither siblings nor crossed
   assign climb = ((lo_ff ^ hi_ff) != ROOT_NODE) && (lo_ff < hi_ff);

   // read data is the sibling of the node written last cycle
   assign upd_wdata = upd_first_ff ? val_ff : max_word(val_ff, rd_a);

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_max   = rsp_max_ff;
   assign rsp_range_error = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= '0;
         sel_a_ff     <= 1'b0;
         sel_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_ff      <= node_in;
         sel_a_ff     <= sel_a_in;
         sel_b_ff     <= sel_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      upd_first_ff <= upd_first_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      pair_ff      <= pair_in;
      best_ff      <= best_in;
      err_ff       <= err_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      val_in       = val_ff;
      upd_first_in = upd_first_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sel_a_in     = 1'b0;
      sel_b_in     = 1'b0;
      pair_in      = max_word(sel_a_ff ? rd_a : FLOOR_VALUE, sel_b_ff ? rd_b : FLOOR_VALUE);
      best_in      = max_word(best_ff, pair_ff);
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_max_in   = rsp_max_ff;
      rsp_err_in   = rsp_err_ff;

      mem_we      = 1'b0;
      mem_waddr   = node_ff;
      mem_wdata   = upd_wdata;
      mem_raddr_a = node_ff ^ ROOT_NODE;
      mem_raddr_b = hi_ff - ROOT_NODE;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (node_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end else begin
               node_in = node_ff + ROOT_NODE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_UPDATE) begin
                  if (upd_ok) begin
                     node_in      = NODE_W'(first_w + LEAVES_C);
                     val_in       = req_new_value;
                     upd_first_in = 1'b1;
                     state_in     = ST_UPDATE;
                  end
               end else begin
                  pair_in = FLOOR_VALUE;
                  best_in = FLOOR_VALUE;
                  lo_in   = NODE_W'(first_w - ONE_C + LEAVES_C);
                  hi_in   = NODE_W'(last_w + ONE_C + LEAVES_C);
                  err_in  = !range_ok;
                  state_in = range_ok ? ST_QUERY : ST_DRAIN;
               end
            end
         end
         ST_UPDATE: begin
            mem_we       = 1'b1;
            val_in       = upd_wdata;
            upd_first_in = 1'b0;
            node_in      = node_ff >> 1;
            if (node_ff == ROOT_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            mem_raddr_a = lo_ff + ROOT_NODE;
            if (climb) begin
               sel_a_in = !lo_ff[0];
               sel_b_in = hi_ff[0];
               lo_in    = lo_ff >> 1;
               hi_in    = hi_ff >> 1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = max_word(best_ff, pair_ff);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rmst_pkg::*;

   localparam int LEAVES           = 1024;
   localparam int LIMIT_CYCLES     = 600000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic     mode;
      idx_type  lo_idx;
      idx_type  hi_idx;
      word_type value;
   } req_word_type;

   typedef struct {
      word_type range_max;
      logic     range_error;
   } max_result_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   logic     req_mode;
   idx_type  req_first_index;
   idx_type  req_last_index;
   word_type req_new_value;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_range_max;
   logic     rsp_range_error;

   word_type       tree_model [0:2*LEAVES-1];
   max_result_type expected_max_q [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int rsp_hold_req   = 0;   // bumped by a test to start a long hold-off
   int rsp_hold_seen  = 0;
   int rsp_hold_left  = 0;

   range_max_segment_tree_core #(
      .LEAVES(LEAVES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_first_index(req_first_index),
      .req_last_index (req_last_index),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_range_max  (rsp_range_max),
      .rsp_range_error(rsp_range_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (rsp_hold_seen != rsp_hold_req) begin
         rsp_hold_seen <= rsp_hold_req;
         rsp_hold_left <= LONG_HOLD_CYCLES - 1;
         rsp_ready     <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input max_result_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s: expected max %0d err %0b, got max %0d err %0b",
                  cycle_count, what, want.range_max, want.range_error,
                  rsp_range_max, rsp_range_error);
   endtask

   always @(posedge clock) begin
      max_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_max_q.size() == 0) begin
            want.range_max   = 'x;
            want.range_error = 1'bx;
            report_mismatch("word with nothing pending", want);
         end else begin
            want = expected_max_q.pop_front();
            if (rsp_range_max !== want.range_max || rsp_range_error !== want.range_error)
               report_mismatch("wrong word", want);
         end
      end
   end

   // ---- tree predictor ----

   function automatic void model_write_leaf(input idx_type pos, input word_type v);
      int node;
      node = int'(pos) + LEAVES;
      tree_model[node] = v;
      while (node > 1) begin
         node = node / 2;
         tree_model[node] = (tree_model[2*node] > tree_model[2*node+1]) ?
                            tree_model[2*node] : tree_model[2*node+1];
      end
   endfunction

   function automatic max_result_type predict_range_max(input idx_type lo_idx,
                                                        input idx_type hi_idx);
      max_result_type r;
      int lo;
      int hi;
      r.range_max   = FLOOR_VALUE;
      r.range_error = 1'b0;
      if (lo_idx < 1 || lo_idx > hi_idx || int'(hi_idx) + 2 > LEAVES) begin
         r.range_error = 1'b1;
         return r;
      end
      // open bounds climb together until they become siblings
      lo = int'(lo_idx) - 1 + LEAVES;
      hi = int'(hi_idx) + 1 + LEAVES;
      while (((lo ^ hi) != 1) && (lo < hi)) begin
         if (lo % 2 == 0 && tree_model[lo+1] > r.range_max)
            r.range_max = tree_model[lo+1];
         if (hi % 2 == 1 && tree_model[hi-1] > r.range_max)
            r.range_max = tree_model[hi-1];
         lo = lo / 2;
         hi = hi / 2;
      end
      return r;
   endfunction

   // ---- stimulus plumbing ----

   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_mode        <= w.mode;
      req_first_index <= w.lo_idx;
      req_last_index  <= w.hi_idx;
      req_new_value   <= w.value;
      do @(posedge clock); while (!req_ready);
      if (w.mode == MODE_UPDATE)
         model_write_leaf(w.lo_idx, w.value);
      else
         expected_max_q.insert(expected_max_q.size(), predict_range_max(w.lo_idx, w.hi_idx));
   endtask

   task automatic send_update(input int pos, input word_type v);
      req_word_type w;
      w.mode   = MODE_UPDATE;
      w.lo_idx = idx_type'(pos);
      w.hi_idx = idx_type'($urandom);
      w.value  = v;
      send_word(w);
   endtask

   task automatic send_query(input int lo_idx, input int hi_idx);
      req_word_type w;
      w.mode   = MODE_QUERY;
      w.lo_idx = idx_type'(lo_idx);
      w.hi_idx = idx_type'(hi_idx);
      w.value  = word_type'($urandom);
      send_word(w);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_max_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // updates cluster on a low window so queries see many written leaves
   function automatic req_word_type random_word();
      req_word_type w;
      w.mode   = 1'($urandom_range(0, 1));
      w.lo_idx = idx_type'($urandom);
      w.hi_idx = idx_type'($urandom);
      w.value  = word_type'($urandom);
      if (w.mode == MODE_UPDATE) begin
         if ($urandom_range(0, 99) < 60)
            w.lo_idx = idx_type'($urandom_range(0, 63));
         case ($urandom_range(0, 3))
            0: ;
            1: w.value = int'($urandom_range(0, 2000)) - 1000;
            2: w.value = FLOOR_VALUE + int'($urandom_range(0, 4)) - 2;
            default: w.value = 32'sh8000_0000 + int'($urandom_range(0, 1000));
         endcase
      end else begin
         case ($urandom_range(0, 9))
            0: ;
            1, 2, 3, 4, 5: begin
               w.lo_idx = idx_type'($urandom_range(1, 63));
               w.hi_idx = idx_type'(int'(w.lo_idx) + int'($urandom_range(0, 15)));
            end
            6, 7: begin
               w.lo_idx = idx_type'($urandom_range(1, LEAVES - 2));
               w.hi_idx = idx_type'($urandom_range(int'(w.lo_idx), LEAVES - 2));
            end
            default: begin
               w.lo_idx = idx_type'($urandom_range(1, 1000));
               w.hi_idx = idx_type'(int'(w.lo_idx) + int'($urandom_range(0, 21)));
            end
         endcase
      end
      return w;
   endfunction

   // ---- tests ----

   task automatic test_cleared_tree();
      send_query(1, LEAVES - 2);
      send_query(1, 1);
      wait_drained();
   endtask

   task automatic test_edge_positions();
      send_update(0, 32'sh7FFF_FFFF);
      send_update(LEAVES - 1, 32'sh7FFF_FFFF);
      send_update(1, 5);
      send_update(LEAVES - 2, -5);
      send_query(1, LEAVES - 2);
      send_update(512, 32'sh8000_0000);
      send_query(512, 512);
      send_query(1, 1);
      send_query(LEAVES - 3, LEAVES - 2);
      wait_drained();
   endtask

   task automatic test_bad_ranges();
      send_query(0, 5);
      send_query(6, 5);
      send_query(1, LEAVES - 1);
      send_query(LEAVES - 1, LEAVES - 1);
      send_query(0, 0);
      send_query(LEAVES - 1, 0);
      wait_drained();
   endtask

   task automatic test_floor_value();
      send_update(7, FLOOR_VALUE);
      send_update(8, FLOOR_VALUE - 1);
      send_query(7, 8);
      send_query(8, 8);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (n) send_word(random_word());
      wait_drained();
   endtask

   // receiver holds off long enough that the output register and the core both fill
   task automatic test_output_backpressure();
      req_word_type w;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      rsp_hold_req++;
      repeat (20) begin
         w        = random_word();
         w.mode   = MODE_QUERY;
         w.lo_idx = idx_type'($urandom_range(1, 200));
         w.hi_idx = idx_type'(int'(w.lo_idx) + int'($urandom_range(0, 40)));
         send_word(w);
      end
      wait_drained();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_UPDATE;
      req_first_index = '0;
      req_last_index  = '0;
      req_new_value   = '0;
      foreach (tree_model[i]) tree_model[i] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_tree();
      test_edge_positions();
      test_bad_ranges();
      test_floor_value();
      test_random_traffic(220, 0, 0);
      test_random_traffic(220, 76, 0);
      test_random_traffic(220, 0, 76);
      test_random_traffic(220, 24, 24);
      test_output_backpressure();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> range_max_segment_tree_core.f
design/rmst_pkg.sv
design/rmst_mem.sv
design/range_max_segment_tree_core.sv
tb/tb.sv
